/* hw/rtl/tcw_pkg.sv */
// Shared definitions for the text console writer: screen geometry,
// item kinds, microcode step names and the control word layout.
// No dependencies.
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  // Row counter can hold ROWS after an advance until a scroll pulls it back.
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [15:0] BLANK_CELL   = 16'h0720;
  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [7:0]  SPACE_CODE   = 8'd32;
  localparam logic [7:0]  ATTR_RESET   = 8'h07;

  localparam int  PADDR_W  = 3;
  localparam logic REG_ATTR = 1'b0;

  typedef enum logic [1:0] {
    KIND_PUT       = 2'd0,
    KIND_BACKSPACE = 2'd1,
    KIND_CLEAR     = 2'd2,
    KIND_READ      = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE   = 4'd0,
    S_PUT    = 4'd1,
    S_NL     = 4'd2,
    S_CHK    = 4'd3,
    S_SCR_RD = 4'd4,
    S_SCR_WR = 4'd5,
    S_BOT    = 4'd6,
    S_BLANK  = 4'd7,
    S_DONE   = 4'd8,
    S_CLR    = 4'd9,
    S_BS     = 4'd10,
    S_BS_WR  = 4'd11,
    S_RD     = 4'd12,
    S_RD_CAP = 4'd13,
    S_INIT   = 4'd15
  } step_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_START,
    C_NO_OVF,
    C_NOT_LAST
  } cond_e;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_ADV,
    CUR_NL,
    CUR_LASTROW,
    CUR_HOME,
    CUR_BACK
  } cur_op_e;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_CHAR,
    MEM_SPACE,
    MEM_COPY,
    MEM_BLANK
  } mem_op_e;

  typedef enum logic [2:0] {
    ADDR_HOLD,
    ADDR_INC,
    ADDR_INPUT,
    ADDR_COLS,
    ADDR_BOTTOM,
    ADDR_ZERO
  } addr_op_e;

  typedef struct packed {
    cond_e    cond;
    step_e    target;
    cur_op_e  cur;
    mem_op_e  mem;
    addr_op_e addr;
    logic     done;
    logic     capture;
  } uword_t;

  typedef struct packed {
    logic no_ovf;
    logic addr_last;
  } dp_status_t;

  function automatic step_e dispatch(kind_e k, logic [7:0] code);
    step_e s;
    case (k)
      KIND_PUT:       s = (code == NEWLINE_CODE) ? S_NL : S_PUT;
      KIND_BACKSPACE: s = S_BS;
      KIND_CLEAR:     s = S_CLR;
      KIND_READ:      s = S_RD;
      default:        s = S_IDLE;
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/tcw_ucode_rom.sv */
// Microcode store of the console writer: one control word per step.
// Depends on tcw_pkg.
module tcw_ucode_rom
  import tcw_pkg::*;
(
  input  step_e  pc_i,
  output uword_t uw_o
);

  function automatic uword_t mk(cond_e c, step_e t, cur_op_e cu, mem_op_e m,
                                addr_op_e a, logic d, logic cap);
    uword_t w;
    w.cond    = c;
    w.target  = t;
    w.cur     = cu;
    w.mem     = m;
    w.addr    = a;
    w.done    = d;
    w.capture = cap;
    return w;
  endfunction

  always_comb begin
    case (pc_i)
      S_IDLE:   uw_o = mk(C_START, S_IDLE, CUR_HOLD, MEM_NONE, ADDR_INPUT, 1'b0, 1'b0);
      S_PUT:    uw_o = mk(C_JUMP, S_CHK, CUR_ADV, MEM_CHAR, ADDR_HOLD, 1'b0, 1'b0);
      S_NL:     uw_o = mk(C_NEXT, S_IDLE, CUR_NL, MEM_NONE, ADDR_HOLD, 1'b0, 1'b0);
      S_CHK:    uw_o = mk(C_NO_OVF, S_DONE, CUR_HOLD, MEM_NONE, ADDR_COLS, 1'b0, 1'b0);
      S_SCR_RD: uw_o = mk(C_NEXT, S_IDLE, CUR_HOLD, MEM_NONE, ADDR_HOLD, 1'b0, 1'b0);
      S_SCR_WR: uw_o = mk(C_NOT_LAST, S_SCR_RD, CUR_HOLD, MEM_COPY, ADDR_INC, 1'b0, 1'b0);
      S_BOT:    uw_o = mk(C_NEXT, S_IDLE, CUR_LASTROW, MEM_NONE, ADDR_BOTTOM, 1'b0, 1'b0);
      S_BLANK:  uw_o = mk(C_NOT_LAST, S_BLANK, CUR_HOLD, MEM_BLANK, ADDR_INC, 1'b0, 1'b0);
      S_DONE:   uw_o = mk(C_JUMP, S_IDLE, CUR_HOLD, MEM_NONE, ADDR_HOLD, 1'b1, 1'b0);
      S_CLR:    uw_o = mk(C_JUMP, S_BLANK, CUR_HOME, MEM_NONE, ADDR_ZERO, 1'b0, 1'b0);
      S_BS:     uw_o = mk(C_NEXT, S_IDLE, CUR_BACK, MEM_NONE, ADDR_HOLD, 1'b0, 1'b0);
      S_BS_WR:  uw_o = mk(C_JUMP, S_DONE, CUR_HOLD, MEM_SPACE, ADDR_HOLD, 1'b0, 1'b0);
      S_RD:     uw_o = mk(C_NEXT, S_IDLE, CUR_HOLD, MEM_NONE, ADDR_HOLD, 1'b0, 1'b0);
      S_RD_CAP: uw_o = mk(C_JUMP, S_DONE, CUR_HOLD, MEM_NONE, ADDR_HOLD, 1'b0, 1'b1);
      // Last step: falling through wraps the step counter to idle.
      S_INIT:   uw_o = mk(C_NOT_LAST, S_INIT, CUR_HOLD, MEM_BLANK, ADDR_INC, 1'b0, 1'b0);
      default:  uw_o = mk(C_JUMP, S_IDLE, CUR_HOLD, MEM_NONE, ADDR_HOLD, 1'b0, 1'b0);
    endcase
  end

endmodule

/* hw/rtl/tcw_datapath.sv */
// Datapath of the console writer: cursor, sweep address, cell memory and
// result registers, all driven by the current control word.
// Depends on tcw_pkg.
module tcw_datapath
  import tcw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  kind_e       kind_i,
  input  logic [7:0]  char_code_i,
  input  logic [10:0] read_address_i,
  input  logic [7:0]  attr_i,
  input  uword_t      uw_i,
  output dp_status_t  status_o,
  output logic        result_valid_o,
  output logic [4:0]  cursor_row_o,
  output logic [6:0]  cursor_col_o,
  output logic        serial_valid_o,
  output logic [7:0]  serial_byte_o,
  output logic [15:0] cell_data_o
);

  logic [15:0] mem [CELLS];
  logic [15:0] rdata_q;

  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  kind_e             kind_q;
  logic [7:0]        code_q;
  logic              oob_q;
  logic [15:0]       cell_q;
  logic              res_valid_q;
  logic [4:0]        res_row_q;
  logic [6:0]        res_col_q;
  logic              res_sv_q;
  logic [7:0]        res_sb_q;
  logic [15:0]       res_cell_q;

  logic [ADDR_W-1:0] cur_lin;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0]       wr_data;
  logic              echo;

  assign cur_lin = ADDR_W'(int'(row_q) * COLUMNS + int'(col_q));

  assign status_o.no_ovf    = (int'(row_q) < ROWS);
  assign status_o.addr_last = (addr_q == ADDR_W'(CELLS - 1));

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    case (uw_i.cur)
      CUR_ADV: begin
        if (col_q == COL_W'(COLUMNS - 1)) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      CUR_NL: begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end
      CUR_LASTROW: row_d = ROW_W'(ROWS - 1);
      CUR_HOME: begin
        row_d = '0;
        col_d = '0;
      end
      CUR_BACK: begin
        // Step back one cell, wrapping to the previous row; stay at origin.
        if (col_q == '0) begin
          if (row_q != '0) begin
            row_d = row_q - 1'b1;
            col_d = COL_W'(COLUMNS - 1);
          end
        end else begin
          col_d = col_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (uw_i.addr)
      ADDR_INC:    addr_d = addr_q + 1'b1;
      ADDR_INPUT:  addr_d = ADDR_W'(read_address_i);
      ADDR_COLS:   addr_d = ADDR_W'(COLUMNS);
      ADDR_BOTTOM: addr_d = ADDR_W'(CELLS - COLUMNS);
      ADDR_ZERO:   addr_d = '0;
      default:     addr_d = addr_q;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = cur_lin;
    wr_data = BLANK_CELL;
    case (uw_i.mem)
      MEM_CHAR:  wr_data = {attr_i, code_q};
      MEM_SPACE: wr_data = {attr_i, SPACE_CODE};
      MEM_COPY: begin
        // Row above the one just read.
        wr_addr = addr_q - ADDR_W'(COLUMNS);
        wr_data = rdata_q;
      end
      MEM_BLANK: wr_addr = addr_q;
      default:   wr_en   = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      addr_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      row_q       <= row_d;
      col_q       <= col_d;
      addr_q      <= addr_d;
      res_valid_q <= uw_i.done;
    end
  end

  assign echo = (kind_q == KIND_PUT) || (kind_q == KIND_BACKSPACE);

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      kind_q <= kind_i;
      code_q <= char_code_i;
      oob_q  <= ({1'b0, read_address_i} >= 12'(CELLS));
      cell_q <= '0;
    end else if (uw_i.capture) begin
      cell_q <= oob_q ? 16'h0000 : rdata_q;
    end
    if (uw_i.done) begin
      res_row_q  <= 5'(row_q);
      res_col_q  <= 7'(col_q);
      res_sv_q   <= echo;
      res_sb_q   <= (kind_q == KIND_PUT) ? code_q :
                    (kind_q == KIND_BACKSPACE) ? SPACE_CODE : 8'h00;
      res_cell_q <= cell_q;
    end
  end

  assign result_valid_o = res_valid_q;
  assign cursor_row_o   = res_row_q;
  assign cursor_col_o   = res_col_q;
  assign serial_valid_o = res_sv_q;
  assign serial_byte_o  = res_sb_q;
  assign cell_data_o    = res_cell_q;

endmodule

/* hw/rtl/text_console_writer.sv */
// Top level of the text console writer: step counter, configuration port,
// microcode store and datapath. Depends on tcw_pkg, tcw_ucode_rom and
// tcw_datapath.
//
// A word is taken when start is high and busy is low; each word yields one
// result, shown for exactly one cycle with result_valid_o, and the next word
// may be started in that same cycle. A put, backspace or read keeps busy high
// through its steps, and no new word is taken until busy falls. Each clock
// runs one step of the microprogram, and the cell memory has one write and
// one registered read port: a newline or wrap that scrolls copies each of the
// ROWS*COLUMNS-COLUMNS cells in a read step and a write step, then blanks the
// bottom row one cell a cycle. Clear blanks the whole screen one cell a cycle.
// After reset busy stays high while the memory is filled with blank cells;
// configuration writes are taken throughout.
module text_console_writer
  import tcw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind_i,
  input  logic [7:0]         char_code_i,
  input  logic [10:0]        read_address_i,
  output logic               result_valid_o,
  output logic [4:0]         cursor_row_o,
  output logic [6:0]         cursor_col_o,
  output logic               serial_valid_o,
  output logic [7:0]         serial_byte_o,
  output logic [15:0]        cell_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  step_e      pc_q, pc_d;
  uword_t     uw;
  dp_status_t status;
  logic [7:0] attr_q;
  logic       accept;

  assign accept = start && !busy;

  tcw_ucode_rom u_rom (
    .pc_i (pc_q),
    .uw_o (uw)
  );

  tcw_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .kind_i         (kind_e'(kind_i)),
    .char_code_i    (char_code_i),
    .read_address_i (read_address_i),
    .attr_i         (attr_q),
    .uw_i           (uw),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .cursor_row_o   (cursor_row_o),
    .cursor_col_o   (cursor_col_o),
    .serial_valid_o (serial_valid_o),
    .serial_byte_o  (serial_byte_o),
    .cell_data_o    (cell_data_o)
  );

  // Next step.
  always_comb begin
    case (uw.cond)
      C_JUMP:     pc_d = uw.target;
      C_START:    pc_d = start ? dispatch(kind_e'(kind_i), char_code_i) : pc_q;
      C_NO_OVF:   pc_d = status.no_ovf ? uw.target : step_e'(4'(pc_q + 1'b1));
      C_NOT_LAST: pc_d = !status.addr_last ? uw.target : step_e'(4'(pc_q + 1'b1));
      default:    pc_d = step_e'(4'(pc_q + 1'b1));
    endcase
  end

  // Handshake outputs.
  always_comb begin
    busy = (pc_q != S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_INIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ATTR)) begin
      attr_q <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_ATTR) ? {24'h000000, attr_q} : 32'h00000000;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after an accepted word");

  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(pc_q) == S_DONE))
    else $error("result strobe without a completion step");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while still busy");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (cursor_row_o < 5'(ROWS)))
    else $error("reported cursor row beyond the last row");

endmodule
